// ===== rtl/core/tap_tempo_estimator_unit_assert.svh =====
// Assertion macros shared by the tap tempo estimator modules.
`ifndef TAP_TEMPO_ESTIMATOR_UNIT_ASSERT_SVH
`define TAP_TEMPO_ESTIMATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TTE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TTE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/tte_pkg.sv =====
// Shared types and constants of the tap tempo estimator.
package tte_pkg;

  localparam int MAX_TAPS_DEF = 8;

  localparam int TIME_W    = 32;
  localparam int TIMEOUT_W = 16;
  localparam int TEMPO_W   = 12;
  localparam int HELD_W    = 4;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd2000;
  localparam logic [TEMPO_W-1:0]   TEMPO_MIN   = 12'd200;
  localparam logic [TEMPO_W-1:0]   TEMPO_MAX   = 12'd3000;

  // Tenths of a beat per minute expressed against a span in milliseconds.
  localparam int TENTHS_PER_MIN_MS = 600000;
  localparam int TPM_W             = 20;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // latch the new tap time
    logic rd;         // read the oldest held tap
    logic drop;       // expire the oldest held tap
    logic store;      // write the new tap and prepare the numerator
    logic span_load;  // form the span and start the divider
    logic div_step;   // one restoring division step
    logic finish;     // load the result and trim the ring
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic expired;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/tte_datapath.sv =====
// Datapath of the tap tempo estimator: tap ring, expiry compare, divider and result register.
module tte_datapath #(
  parameter int MAX_TAPS = tte_pkg::MAX_TAPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tte_pkg::TIME_W-1:0]    in_tap_time_ms,
  input  logic                          cfg_we,
  input  logic [tte_pkg::TIMEOUT_W-1:0] cfg_wdata,
  input  tte_pkg::cmd_t                 cmd,
  output tte_pkg::sts_t                 sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_tempo_valid,
  output logic [tte_pkg::TEMPO_W-1:0]   out_tempo_tenths_bpm,
  output logic [tte_pkg::HELD_W-1:0]    out_taps_held
);

  localparam int RING   = MAX_TAPS + 1;
  localparam int IDX_W  = $clog2(RING);
  localparam int CNT_W  = $clog2(MAX_TAPS + 2);
  localparam int NUM_W  = $clog2(tte_pkg::TENTHS_PER_MIN_MS * MAX_TAPS + 1);
  localparam int PROD_W = tte_pkg::TPM_W + CNT_W;
  localparam int DCNT_W = $clog2(NUM_W + 1);
  localparam int TW     = tte_pkg::TIME_W;

  logic [TW-1:0]    tap_mem [RING];
  logic [TW-1:0]    rd_data_r;
  logic [TW-1:0]    now_r;
  logic [IDX_W-1:0] oldest_r;
  logic [CNT_W-1:0] count_r;
  logic [tte_pkg::TIMEOUT_W-1:0] timeout_r;

  logic [NUM_W-1:0]  num_r;
  logic [TW-1:0]     span_r;
  logic [TW-1:0]     rem_r;
  logic [NUM_W-1:0]  quo_r;
  logic [DCNT_W-1:0] dcnt_r;

  logic                        out_valid_r;
  logic                        out_tv_r;
  logic [tte_pkg::TEMPO_W-1:0] out_tempo_r;
  logic [tte_pkg::HELD_W-1:0]  out_held_r;

  // Ring addressing: successor of the oldest slot and the slot after the newest.
  logic [IDX_W-1:0] oldest_inc;
  logic [IDX_W:0]   wr_sum;
  logic [IDX_W-1:0] wr_addr;
  logic             over_max;
  logic             drop_now;

  always_comb begin
    oldest_inc = (oldest_r == IDX_W'(RING - 1)) ? '0 : oldest_r + 1'b1;
    wr_sum     = {1'b0, oldest_r} + (IDX_W + 1)'(count_r);
    if (wr_sum >= (IDX_W + 1)'(RING)) begin
      wr_addr = IDX_W'(wr_sum - (IDX_W + 1)'(RING));
    end else begin
      wr_addr = wr_sum[IDX_W-1:0];
    end
    over_max = count_r > CNT_W'(MAX_TAPS);
    drop_now = cmd.drop || (cmd.finish && over_max);
  end

  // Numerator 600000 * (taps - 1); count_r still holds taps - 1 when the new tap is stored.
  logic [PROD_W-1:0] prod;
  assign prod = PROD_W'(tte_pkg::TENTHS_PER_MIN_MS) * PROD_W'(count_r);

  // Restoring division step, one quotient bit a cycle.
  logic [TW:0]      rem_sh;
  logic             rem_ge;
  logic [TW-1:0]    rem_nxt;
  logic [NUM_W-1:0] quo_nxt;

  always_comb begin
    rem_sh  = {rem_r, quo_r[NUM_W-1]};
    rem_ge  = rem_sh >= {1'b0, span_r};
    rem_nxt = rem_ge ? TW'(rem_sh - {1'b0, span_r}) : TW'(rem_sh);
    quo_nxt = {quo_r[NUM_W-2:0], rem_ge};
  end

  // Result fields. A zero span yields an all-ones quotient, which clamps to the maximum.
  logic                        tv_nxt;
  logic [tte_pkg::TEMPO_W-1:0] tempo_nxt;
  logic [CNT_W+tte_pkg::HELD_W-1:0] held_ext;

  always_comb begin
    tv_nxt = count_r >= CNT_W'(2);
    if (!tv_nxt) begin
      tempo_nxt = '0;
    end else if (quo_r > NUM_W'(tte_pkg::TEMPO_MAX)) begin
      tempo_nxt = tte_pkg::TEMPO_MAX;
    end else if (quo_r < NUM_W'(tte_pkg::TEMPO_MIN)) begin
      tempo_nxt = tte_pkg::TEMPO_MIN;
    end else begin
      tempo_nxt = quo_r[tte_pkg::TEMPO_W-1:0];
    end
    held_ext = (CNT_W + tte_pkg::HELD_W)'(count_r);
  end

  // Tap memory: one write port, one registered read port at the oldest slot.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      tap_mem[wr_addr] <= now_r;
    end
    if (cmd.rd) begin
      rd_data_r <= tap_mem[oldest_r];
    end
  end

  // Ring control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r  <= '0;
      count_r   <= '0;
      timeout_r <= tte_pkg::TIMEOUT_RST;
    end else begin
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
      if (drop_now) begin
        oldest_r <= oldest_inc;
        count_r  <= count_r - 1'b1;
      end else if (cmd.store) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // Tap time, numerator and divider registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      now_r <= in_tap_time_ms;
    end
    if (cmd.store) begin
      num_r <= prod[NUM_W-1:0];
    end
    if (cmd.span_load) begin
      span_r <= now_r - rd_data_r;
      rem_r  <= '0;
      quo_r  <= num_r;
      dcnt_r <= DCNT_W'(NUM_W);
    end else if (cmd.div_step) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  // Output register: holds one result until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_tv_r    <= tv_nxt;
      out_tempo_r <= tempo_nxt;
      out_held_r  <= held_ext[tte_pkg::HELD_W-1:0];
    end
  end

  // Status towards the controller.
  always_comb begin
    sts.count_zero = count_r == '0;
    sts.expired    = (now_r - rd_data_r) > TW'(timeout_r);
    sts.div_last   = dcnt_r == DCNT_W'(1);
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid            = out_valid_r;
  assign out_tempo_valid      = out_tv_r;
  assign out_tempo_tenths_bpm = out_tempo_r;
  assign out_taps_held        = out_held_r;

`include "tap_tempo_estimator_unit_assert.svh"

  // The ring never holds more than one tap beyond the limit, and is trimmed on finish.
  `TTE_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_TAPS + 1), "tap count overflow")
  `TTE_ASSERT_NXT(a_trim_after_finish, cmd.finish, count_r <= CNT_W'(MAX_TAPS), "ring not trimmed")
  `TTE_ASSERT_IMP(a_oldest_range, 1'b1, oldest_r <= IDX_W'(RING - 1), "oldest slot out of ring")
  `TTE_ASSERT_IMP(a_tempo_range, out_valid_r && out_tv_r, (out_tempo_r >= tte_pkg::TEMPO_MIN) && (out_tempo_r <= tte_pkg::TEMPO_MAX), "tempo out of range")

endmodule

// ===== rtl/core/tte_ctrl.sv =====
// Controller state machine of the tap tempo estimator.
module tte_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tte_pkg::sts_t sts,
  output tte_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXP_RD,
    ST_EXP_CHK,
    ST_STORE,
    ST_SPAN,
    ST_DIV,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXP_RD;
        end
      end
      ST_EXP_RD: begin
        if (sts.count_zero) begin
          state_nxt = ST_STORE;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = ST_EXP_CHK;
        end
      end
      ST_EXP_CHK: begin
        if (sts.expired) begin
          cmd.drop  = 1'b1;
          state_nxt = ST_EXP_RD;
        end else begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        // Store the new tap and fetch the oldest for the span in the same cycle.
        cmd.store = 1'b1;
        cmd.rd    = 1'b1;
        state_nxt = sts.count_zero ? ST_FINISH : ST_SPAN;
      end
      ST_SPAN: begin
        cmd.span_load = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= state_nxt == ST_IDLE;
    end
  end

  assign in_ready = in_ready_r;

`include "tap_tempo_estimator_unit_assert.svh"

  // Ready is only offered while idle; commands other than rd never overlap.
  `TTE_ASSERT_IMP(a_ready_idle, in_ready_r, state_r == ST_IDLE, "ready outside idle")
  `TTE_ASSERT_IMP(a_cmd_exclusive, 1'b1, $onehot0({cmd.accept, cmd.drop, cmd.store, cmd.span_load, cmd.div_step, cmd.finish}), "overlapping commands")

endmodule

// ===== rtl/core/tap_tempo_estimator_unit.sv =====
// Tap tempo estimator top level: tempo in tenths of BPM from a ring of recent tap times.
// One request at a time: an accept step, a read and a compare for each held tap checked for
// expiry (a step with no read if the ring runs empty), the store, then the span load and the
// divider steps when a tap is already held, and the result load once the output is free.
// A finished result waits in the output register while the next tap is taken in.
// Synchronous active-low reset empties the ring and restores the 2000 ms timeout.
module tap_tempo_estimator_unit #(
  parameter int MAX_TAPS = tte_pkg::MAX_TAPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tte_pkg::TIME_W-1:0]    in_tap_time_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_tempo_valid,
  output logic [tte_pkg::TEMPO_W-1:0]   out_tempo_tenths_bpm,
  output logic [tte_pkg::HELD_W-1:0]    out_taps_held,
  input  logic                          cfg_we,
  input  logic [tte_pkg::TIMEOUT_W-1:0] cfg_wdata
);

  tte_pkg::cmd_t cmd;
  tte_pkg::sts_t sts;

  // Sequencer.
  tte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Ring, divider and result register.
  tte_datapath #(
    .MAX_TAPS (MAX_TAPS)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_tap_time_ms       (in_tap_time_ms),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_tempo_valid      (out_tempo_valid),
    .out_tempo_tenths_bpm (out_tempo_tenths_bpm),
    .out_taps_held        (out_taps_held)
  );

endmodule

// ===== sim/tb_tap_tempo_estimator_unit.sv =====
// Self-checking testbench for the tap tempo estimator, with directed and random tap requests.
`timescale 1ns / 1ps

module tb_tap_tempo_estimator_unit;

  localparam int MAX_TAPS_DEF      = tte_pkg::MAX_TAPS_DEF;
  localparam int TIME_W            = tte_pkg::TIME_W;
  localparam int TIMEOUT_W         = tte_pkg::TIMEOUT_W;
  localparam int TEMPO_W           = tte_pkg::TEMPO_W;
  localparam int HELD_W            = tte_pkg::HELD_W;
  localparam int TENTHS_PER_MIN_MS = tte_pkg::TENTHS_PER_MIN_MS;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = tte_pkg::TIMEOUT_RST;
  localparam logic [TEMPO_W-1:0]   TEMPO_MIN   = tte_pkg::TEMPO_MIN;
  localparam logic [TEMPO_W-1:0]   TEMPO_MAX   = tte_pkg::TEMPO_MAX;

  localparam int RING_DEPTH = MAX_TAPS_DEF + 1;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES = 10;
  localparam int TAPS_PER_PHASE = 65;

  typedef struct packed {
    logic               ok;
    logic [TEMPO_W-1:0] tenths;
    logic [HELD_W-1:0]  held;
  } tempo_result_t;

  typedef struct packed {
    logic                 set_timeout;
    logic [TIMEOUT_W-1:0] timeout;
    logic [TIME_W-1:0]    stamp;
    logic                 typed;
    tempo_result_t        res;
  } tap_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [TIME_W-1:0]    in_tap_time_ms = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_tempo_valid;
  logic [TEMPO_W-1:0]   out_tempo_tenths_bpm;
  logic [HELD_W-1:0]    out_taps_held;
  logic                 cfg_we = 1'b0;
  logic [TIMEOUT_W-1:0] cfg_wdata = '0;

  // Shadow copy of the tap ring and the timeout register.
  logic [TIME_W-1:0]    tap_ring [RING_DEPTH];
  int unsigned          ring_head;
  int unsigned          ring_fill;
  logic [TIMEOUT_W-1:0] timeout_ms;

  tempo_result_t pending_tempos [$];
  tap_row_t      tap_rows [$];
  int unsigned   fault_count = 0;
  int unsigned   idle_cycles = 0;
  bit            burst = 1'b0;

  tap_tempo_estimator_unit i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_tap_time_ms       (in_tap_time_ms),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_tempo_valid      (out_tempo_valid),
    .out_tempo_tenths_bpm (out_tempo_tenths_bpm),
    .out_taps_held        (out_taps_held),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Predict the tempo for one tap and update the shadow ring.
  task automatic predict_tempo(input logic [TIME_W-1:0] now, output tempo_result_t res);
    logic [TIME_W-1:0] age;
    logic [63:0]       num;
    logic [63:0]       quot;
    bit                scanning;
    scanning = 1'b1;
    res = '0;
    // Expire from the oldest end, stopping at the first tap still in time.
    while (scanning && ring_fill > 0) begin
      age = now - tap_ring[ring_head];
      if (age > {16'd0, timeout_ms}) begin
        ring_head = (ring_head + 1) % RING_DEPTH;
        ring_fill--;
      end else begin
        scanning = 1'b0;
      end
    end
    if (ring_fill >= RING_DEPTH) begin
      ring_head = (ring_head + 1) % RING_DEPTH;
      ring_fill--;
    end
    tap_ring[(ring_head + ring_fill) % RING_DEPTH] = now;
    ring_fill++;
    // Tempo from the span between the newest and the oldest held tap.
    if (ring_fill >= 2) begin
      age = now - tap_ring[ring_head];
      res.ok = 1'b1;
      if (age == 0) begin
        res.tenths = TEMPO_MAX;
      end else begin
        num = TENTHS_PER_MIN_MS;
        num = num * (ring_fill - 1);
        quot = num / {32'd0, age};
        if (quot > TEMPO_MAX) quot = TEMPO_MAX;
        if (quot < TEMPO_MIN) quot = TEMPO_MIN;
        res.tenths = quot[TEMPO_W-1:0];
      end
    end
    res.held = ring_fill[HELD_W-1:0];
    if (ring_fill > MAX_TAPS_DEF) begin
      ring_head = (ring_head + 1) % RING_DEPTH;
      ring_fill--;
    end
  endtask

  task automatic report_fault(input string what, input int unsigned want, input int unsigned got);
    fault_count++;
    if (fault_count <= 10)
      $display("mismatch in %s: expected %0d, got %0d", what, want, got);
  endtask

  // Let every outstanding request drain, then write the timeout register.
  task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_tempos.size() != 0) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    timeout_ms = value;
  endtask

  // Offer one tap request and record its expected result once accepted.
  task automatic send_tap(input logic [TIME_W-1:0] stamp, input bit typed,
                          input tempo_result_t typed_res);
    int unsigned   gap;
    tempo_result_t res;
    gap = burst ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_tap_time_ms <= stamp;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    predict_tempo(stamp, res);
    pending_tempos.insert(pending_tempos.size(), typed ? typed_res : res);
  endtask

  task automatic add_row(input bit set_to, input int unsigned to, input logic [TIME_W-1:0] stamp,
                         input bit typed, input bit ok, input int unsigned tenths,
                         input int unsigned held);
    tap_row_t row;
    row.set_timeout = set_to;
    row.timeout = to[TIMEOUT_W-1:0];
    row.stamp = stamp;
    row.typed = typed;
    row.res.ok = ok;
    row.res.tenths = tenths[TEMPO_W-1:0];
    row.res.held = held[HELD_W-1:0];
    tap_rows.insert(tap_rows.size(), row);
  endtask

  // Result side: random back-pressure and comparison against the oldest expectation.
  initial begin : result_sink
    int unsigned   stall;
    tempo_result_t want;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = burst ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      if (pending_tempos.size() == 0) begin
        report_fault("result with no request pending, taps held", 0, out_taps_held);
      end else begin
        want = pending_tempos.pop_front();
        if (out_tempo_valid !== want.ok)
          report_fault("tempo_valid", want.ok, out_tempo_valid);
        if (out_tempo_tenths_bpm !== want.tenths)
          report_fault("tempo_tenths_bpm", want.tenths, out_tempo_tenths_bpm);
        if (out_taps_held !== want.held)
          report_fault("taps_held", want.held, out_taps_held);
      end
    end
  end

  // Watchdog: too long without any accepted request or taken result means the block has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Main stimulus: reset, directed taps, then random phases.
  initial begin : tap_source
    logic [TIME_W-1:0] stamp;
    int unsigned       step_hi;
    int unsigned       pick;
    tempo_result_t     no_res;
    no_res = '0;
    for (int i = 0; i < RING_DEPTH; i++) tap_ring[i] = '0;
    ring_head = 0;
    ring_fill = 0;
    timeout_ms = TIMEOUT_RST;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // First tap, zero span, plain estimate, then full expiry.
    add_row(0, 0, 32'd1000, 1, 0, 0, 1);
    add_row(0, 0, 32'd1000, 1, 1, 3000, 2);
    add_row(0, 0, 32'd1500, 1, 1, 2400, 3);
    add_row(0, 0, 32'd5000, 1, 0, 0, 1);
    // A tap exactly at the timeout is kept; one beyond it expires.
    add_row(0, 0, 32'd7000, 1, 1, 300, 2);
    add_row(0, 0, 32'd9000, 1, 1, 300, 2);
    // Widest timeout: a long span clamps to the slowest tempo.
    add_row(1, 65535, 32'd69000, 1, 1, 200, 3);
    add_row(0, 0, 32'hFFFF_FFFF, 1, 0, 0, 1);
    // Timestamp wraps through zero.
    add_row(0, 0, 32'd499, 0, 0, 0, 0);
    // Zero timeout keeps only taps with the same time.
    add_row(1, 0, 32'd499, 1, 1, 3000, 2);
    add_row(0, 0, 32'd500, 1, 0, 0, 1);
    // Expiry stops at the first tap in time, even with a later tap ahead of the new one.
    add_row(1, 1000, 32'd5000, 0, 0, 0, 0);
    add_row(0, 0, 32'd5900, 0, 0, 0, 0);
    add_row(0, 0, 32'd5500, 0, 0, 0, 0);
    // Fill the ring to its full depth, past the tap limit.
    add_row(1, 65535, 32'd10000, 0, 0, 0, 0);
    for (int i = 1; i <= 7; i++) add_row(0, 0, 32'd10000 + 500 * i, 0, 0, 0, 0);
    add_row(0, 0, 32'd0, 0, 0, 0, 0);
    add_row(1, 1, 32'd1, 0, 0, 0, 0);

    foreach (tap_rows[i]) begin
      if (tap_rows[i].set_timeout) write_timeout(tap_rows[i].timeout);
      send_tap(tap_rows[i].stamp, tap_rows[i].typed, tap_rows[i].res);
    end

    // Random phases, each with its own timeout and idling pattern.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: write_timeout(16'hFFFF);
        1: write_timeout(16'd1);
        2: write_timeout(16'd0);
        3: write_timeout(TIMEOUT_RST);
        9: write_timeout(TIMEOUT_W'($urandom_range(0, 65535)));
        default: write_timeout(TIMEOUT_W'($urandom_range(300, 4000)));
      endcase
      burst = ($urandom_range(0, 3) == 0);
      step_hi = timeout_ms + timeout_ms / 8 + 2;
      stamp = $urandom;
      for (int n = 0; n < TAPS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)
          stamp = stamp + $urandom_range(step_hi / 8, step_hi);
        else if (pick < 80)
          stamp = stamp + $urandom_range(0, 2);
        else if (pick < 90)
          stamp = stamp + timeout_ms + $urandom_range(1, 100000);
        else
          stamp = $urandom;
        send_tap(stamp, 1'b0, no_res);
      end
    end

    // Drain and give the block time to show any stray result.
    burst = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_tempos.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fault_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
